FILE: src/uule_pkg.sv
package uule_pkg;

    localparam logic [6:0] CHAR_BASE  = 7'd32;
    localparam logic [6:0] CHAR_NL    = 7'd10;
    localparam logic [1:0] GROUP_FULL = 2'd2;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_DATA  = 1'b1;

    // work for the back end that one accepted item leaves behind
    typedef struct packed {
        logic        len_v;
        logic [6:0]  len_char;
        logic        grp_v;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic        nl_v;
        logic        nl_last;
        logic [31:0] sum_old;
        logic [31:0] sum_new;
    } uule_entry_t;

endpackage

FILE: src/uuencode_line_encoder.sv
// path: an accepted item's entry is written to the queue, then loaded into the output register
// input: one item per cycle while the entry queue has room; full rises when it fills
// output: one character per cycle from the back-end sequencer while pop is asserted; a data
// byte yields 0 to 5 characters, so sustained byte rate is set by the sequencer
// reset: asynchronous, clears transfer state, queue pointers, output valid flag and total_length
module uuencode_line_encoder #(
    parameter int LINE_BYTES  = 45,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  out_char,
    output logic [31:0] running_sum,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uule_pkg::*;

    localparam logic [2:0] ADDR_TOTAL_LENGTH = 3'd0;

    logic [15:0] total_length_reg;
    logic        item_valid;
    logic        entry_valid;
    uule_entry_t entry;
    uule_entry_t head;
    logic        q_valid;
    logic        q_pop;

    assign pready     = 1'b1;
    assign item_valid = push && !full;
    assign prdata     = (paddr == ADDR_TOTAL_LENGTH) ? {16'd0, total_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_length_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_TOTAL_LENGTH)
            total_length_reg <= pwdata[15:0];
    end

    uule_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .kind        (kind),
        .data_byte   (data_byte),
        .total_length(total_length_reg),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    uule_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (entry_valid),
        .wr_data  (entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (head),
        .not_empty(q_valid)
    );

    uule_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .running_sum(running_sum),
        .last       (last)
    );

endmodule

FILE: src/uule_front.sv
module uule_front #(
    parameter int LINE_BYTES = 45
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          total_length,
    output logic                 entry_valid,
    output uule_pkg::uule_entry_t entry
);
    import uule_pkg::*;

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam logic [15:0]   LINE_BYTES16 = 16'(LINE_BYTES);
    localparam logic [LW-1:0] LINE_LEN     = LW'(LINE_BYTES);
    localparam logic [LW-1:0] GROUP_BYTES  = LW'(3);

    logic [15:0]   bytes_left_reg, bytes_left_next;
    logic [LW-1:0] line_left_reg, line_left_next;
    logic [1:0]    group_pos_reg, group_pos_next;
    logic [15:0]   held_reg, held_next;
    logic [31:0]   sum_reg, sum_next;
    logic          active_reg, active_next;

    logic [LW-1:0] open_len;
    logic [LW-1:0] ll;
    logic [1:0]    gp;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        line_left_next  = line_left_reg;
        group_pos_next  = group_pos_reg;
        held_next       = held_reg;
        sum_next        = sum_reg;
        active_next     = active_reg;
        entry           = '0;
        ll              = line_left_reg;
        gp              = group_pos_reg;

        if (bytes_left_reg < LINE_BYTES16)
            open_len = bytes_left_reg[LW-1:0];
        else
            open_len = LINE_LEN;

        if (item_valid)
        begin
            if (kind == KIND_START)
            begin
                bytes_left_next = total_length;
                group_pos_next  = '0;
                held_next       = '0;
                sum_next        = '0;
                entry.len_v     = 1'b1;
                if (total_length == '0)
                begin
                    line_left_next = '0;
                    active_next    = 1'b0;
                    entry.len_char = CHAR_BASE;
                    entry.nl_v     = 1'b1;
                    entry.nl_last  = 1'b1;
                end
                else
                begin
                    active_next = 1'b1;
                    if (total_length < LINE_BYTES16)
                        line_left_next = total_length[LW-1:0];
                    else
                        line_left_next = LINE_LEN;
                    entry.len_char = CHAR_BASE + 7'(line_left_next);
                end
            end
            else if (active_reg && bytes_left_reg != '0)
            begin
                if (ll == '0)
                begin
                    ll             = open_len;
                    gp             = '0;
                    entry.len_v    = 1'b1;
                    entry.len_char = CHAR_BASE + 7'(open_len);
                end
                entry.sum_old = sum_reg;
                entry.sum_new = sum_reg;

                if (gp == '0 && ll < GROUP_BYTES)
                begin
                    // tail of a partial group: byte dropped
                end
                else if (gp < GROUP_FULL)
                begin
                    held_next = {held_reg[7:0], data_byte};
                    gp        = gp + 2'd1;
                end
                else
                begin
                    entry.grp_v   = 1'b1;
                    entry.a       = held_reg[15:8];
                    entry.b       = held_reg[7:0];
                    entry.c       = data_byte;
                    sum_next      = sum_reg + 32'(held_reg[15:8]) + 32'(held_reg[7:0])
                                  + 32'(data_byte);
                    entry.sum_new = sum_next;
                    gp            = '0;
                    held_next     = '0;
                end

                ll              = ll - LW'(1);
                bytes_left_next = bytes_left_reg - 16'd1;
                if (ll == '0)
                begin
                    gp            = '0;
                    held_next     = '0;
                    entry.nl_v    = 1'b1;
                    entry.nl_last = (bytes_left_next == '0);
                    if (bytes_left_next == '0)
                        active_next = 1'b0;
                end
                line_left_next = ll;
                group_pos_next = gp;
            end
        end
        entry_valid = entry.len_v | entry.grp_v | entry.nl_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            line_left_reg  <= '0;
            group_pos_reg  <= '0;
            held_reg       <= '0;
            sum_reg        <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            line_left_reg  <= line_left_next;
            group_pos_reg  <= group_pos_next;
            held_reg       <= held_next;
            sum_reg        <= sum_next;
            active_reg     <= active_next;
        end
    end

endmodule

FILE: src/uule_queue.sv
module uule_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  uule_pkg::uule_entry_t wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output uule_pkg::uule_entry_t rd_data,
    output logic                  not_empty
);
    import uule_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    uule_entry_t   entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/uule_back.sv
module uule_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  uule_pkg::uule_entry_t head,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [6:0]            out_char,
    output logic [31:0]           running_sum,
    output logic                  last
);
    import uule_pkg::*;

    localparam logic [2:0] STEP_LEN = 3'd0;
    localparam logic [2:0] STEP_G0  = 3'd1;
    localparam logic [2:0] STEP_G1  = 3'd2;
    localparam logic [2:0] STEP_G2  = 3'd3;
    localparam logic [2:0] STEP_G3  = 3'd4;
    localparam logic [2:0] STEP_NL  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg, char_next;
    logic [31:0] sum_reg, sum_next;
    logic        last_reg, last_next;

    logic [5:0]  steps;
    logic [5:0]  pending;
    logic [2:0]  cur;
    logic        more;
    logic        load;

    assign steps   = {head.nl_v, {4{head.grp_v}}, head.len_v};
    assign pending = steps & (6'h3f << phase_reg);
    assign load    = q_valid && (!out_valid_reg || pop);

    always_comb
    begin
        cur = STEP_NL;
        for (int i = 5; i >= 0; i--)
        begin
            if (pending[i])
                cur = 3'(i);
        end
        more = |(steps & (6'h3f << (cur + 3'd1)));
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pop;
        char_next      = char_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            sum_next       = head.sum_new;
            last_next      = 1'b0;
            case (cur)
                STEP_LEN:
                begin
                    char_next = head.len_char;
                    sum_next  = head.sum_old;
                end
                STEP_G0: char_next = CHAR_BASE + 7'(head.a[7:2]);
                STEP_G1: char_next = CHAR_BASE + 7'({head.a[1:0], head.b[7:4]});
                STEP_G2: char_next = CHAR_BASE + 7'({head.b[3:0], head.c[7:6]});
                STEP_G3: char_next = CHAR_BASE + 7'(head.c[5:0]);
                STEP_NL:
                begin
                    char_next = CHAR_NL;
                    last_next = head.nl_last;
                end
                default: char_next = CHAR_NL;
            endcase
            if (more)
                phase_next = cur + 3'd1;
            else
            begin
                phase_next = STEP_LEN;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= STEP_LEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        sum_reg  <= sum_next;
        last_reg <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign out_char    = char_reg;
    assign running_sum = sum_reg;
    assign last        = last_reg;

endmodule

FILE: src/uule_checker.sv
module uule_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [6:0]  out_char,
    input logic [31:0] running_sum,
    input logic        last
);

    // no beat may be offered while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result offered during reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(running_sum)
                              && $stable(last)))
        else $error("stalled result changed");

    // every character is a newline or a printable encoding character
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_char == 7'd10 || (out_char >= 7'd32 && out_char <= 7'd95)))
        else $error("character out of range");

    // end of transfer only on a newline
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> out_char == 7'd10)
        else $error("last on a character other than newline");

endmodule

bind uuencode_line_encoder uule_checker u_uule_checker (.*);

FILE: test/tb_uuencode_line_encoder.sv
`timescale 1ns / 1ps

module tb_uuencode_line_encoder;

    import uule_pkg::*;

    localparam int         LINE_LEN        = 45;
    localparam logic [2:0] ADDR_TOTAL_LEN  = 3'd0;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         QUIET_LIMIT     = 4000;
    localparam int         RAND_ITEMS      = 80;
    localparam int         NUM_PHASES      = 4;

    typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_op_t;

    typedef struct {
        row_op_t     op;
        logic [15:0] len;
        logic        kind;
        logic [7:0]  dbyte;
        bit          typed;
        int          n;
        logic [6:0]  ch0;
        logic [6:0]  ch1;
    } stim_row_t;

    typedef struct packed {
        logic [6:0]  ch;
        logic [31:0] sum;
        logic        fin;
    } enc_char_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [6:0]  out_char;
    logic [31:0] running_sum;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    uuencode_line_encoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .running_sum (running_sum),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // encoder state mirror
    logic [15:0] len_reg;
    logic [15:0] rem_bytes;
    logic [5:0]  line_rem;
    logic [1:0]  grp_cnt;
    logic [15:0] grp_hold;
    logic [31:0] sum_acc;
    logic        xfer_on;

    enc_char_t   exp_chars[$];
    enc_char_t   want;
    stim_row_t   dir_rows[$];
    int          err_cnt;
    int          quiet_cycles;
    int          idle_pct;
    int          stall_pct;
    int          emit_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void emit_char(input logic [6:0] ch, input logic fin);
        enc_char_t e;
        e.ch  = ch;
        e.sum = sum_acc;
        e.fin = fin;
        exp_chars.push_back(e);
        emit_cnt++;
    endfunction

    function automatic logic [5:0] line_bytes_for(input logic [15:0] left);
        return (left < LINE_LEN) ? left[5:0] : 6'(LINE_LEN);
    endfunction

    function automatic void encode_item(input logic k, input logic [7:0] b);
        logic [7:0] a;
        logic [7:0] m;
        if (k == KIND_START) begin
            rem_bytes = len_reg;
            grp_cnt   = 2'd0;
            grp_hold  = 16'd0;
            sum_acc   = 32'd0;
            if (rem_bytes == 16'd0) begin
                line_rem = 6'd0;
                xfer_on  = 1'b0;
                emit_char(CHAR_BASE, 1'b0);
                emit_char(CHAR_NL, 1'b1);
            end
            else begin
                xfer_on  = 1'b1;
                line_rem = line_bytes_for(rem_bytes);
                emit_char(CHAR_BASE + {1'b0, line_rem}, 1'b0);
            end
            return;
        end
        if (!xfer_on || rem_bytes == 16'd0)
            return;
        // length char of a later line rides on its first data beat
        if (line_rem == 6'd0) begin
            line_rem = line_bytes_for(rem_bytes);
            grp_cnt  = 2'd0;
            emit_char(CHAR_BASE + {1'b0, line_rem}, 1'b0);
        end
        if (grp_cnt == 2'd0 && line_rem < 6'd3) begin
            // tail of a line too short for a group: dropped
        end
        else if (grp_cnt < GROUP_FULL) begin
            grp_hold = {grp_hold[7:0], b};
            grp_cnt  = grp_cnt + 2'd1;
        end
        else begin
            a = grp_hold[15:8];
            m = grp_hold[7:0];
            sum_acc = sum_acc + 32'(a) + 32'(m) + 32'(b);
            emit_char(CHAR_BASE + {1'b0, a[7:2]}, 1'b0);
            emit_char(CHAR_BASE + {1'b0, a[1:0], m[7:4]}, 1'b0);
            emit_char(CHAR_BASE + {1'b0, m[3:0], b[7:6]}, 1'b0);
            emit_char(CHAR_BASE + {1'b0, b[5:0]}, 1'b0);
            grp_cnt  = 2'd0;
            grp_hold = 16'd0;
        end
        line_rem  = line_rem - 6'd1;
        rem_bytes = rem_bytes - 16'd1;
        if (line_rem == 6'd0) begin
            grp_cnt  = 2'd0;
            grp_hold = 16'd0;
            if (rem_bytes == 16'd0) begin
                xfer_on = 1'b0;
                emit_char(CHAR_NL, 1'b1);
            end
            else begin
                emit_char(CHAR_NL, 1'b0);
            end
        end
    endfunction

    function automatic void add_row(input row_op_t op, input logic [15:0] len,
                                    input logic k, input logic [7:0] b, input bit typed,
                                    input int n, input logic [6:0] c0, input logic [6:0] c1);
        stim_row_t r;
        r.op    = op;
        r.len   = len;
        r.kind  = k;
        r.dbyte = b;
        r.typed = typed;
        r.n     = n;
        r.ch0   = c0;
        r.ch1   = c1;
        dir_rows.push_back(r);
    endfunction

    function automatic void set_phase(input int p);
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 12; stall_pct = 12; end
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_item(input logic k, input logic [7:0] b, input bit typed,
                             input int n, input logic [6:0] c0, input logic [6:0] c1);
        int        base;
        enc_char_t e;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        // count own entries so a pop at this same edge cannot skew the swap
        base = emit_cnt;
        encode_item(k, b);
        if (typed) begin
            repeat (emit_cnt - base)
                void'(exp_chars.pop_back());
            for (int i = 0; i < n; i++) begin
                e.ch  = (i == 0) ? c0 : c1;
                e.sum = 32'd0;
                e.fin = (e.ch == CHAR_NL);
                exp_chars.push_back(e);
            end
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (exp_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_total_len(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOTAL_LEN;
        pwdata  <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        len_reg = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {16'd0, v}) begin
            if (err_cnt < 10)
                $display("total_length readback: expected %0h got %0h", v, prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (exp_chars.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected char %0d sum %0h last %0b",
                             out_char, running_sum, last);
                err_cnt++;
            end
            else begin
                want = exp_chars.pop_front();
                if (out_char !== want.ch || running_sum !== want.sum || last !== want.fin) begin
                    if (err_cnt < 10)
                        $display("char: expected %0d/%0h/%0b got %0d/%0h/%0b",
                                 want.ch, want.sum, want.fin, out_char, running_sum, last);
                    err_cnt++;
                end
            end
        end
    end

    // any beat on either side restarts the count
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin
        int          rand_cnt;
        int          tr;
        int          r;
        int          n_data;
        logic [15:0] len;
        push         = 1'b0;
        kind         = KIND_START;
        data_byte    = 8'd0;
        pop          = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ADDR_TOTAL_LEN;
        pwdata       = 32'd0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        quiet_cycles = 0;
        emit_cnt     = 0;
        len_reg      = 16'd0;
        rem_bytes    = 16'd0;
        line_rem     = 6'd0;
        grp_cnt      = 2'd0;
        grp_hold     = 16'd0;
        sum_acc      = 32'd0;
        xfer_on      = 1'b0;
        set_phase(0);

        // empty transfer, then a beat while idle
        add_row(ROW_CFG,  16'd0,     KIND_START, 8'h00, 1, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 2, CHAR_BASE, CHAR_NL);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hFF, 1, 0, 7'd0, 7'd0);
        // one full group, then a beat after the transfer is done
        add_row(ROW_CFG,  16'd3,     KIND_START, 8'h00, 1, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 1, CHAR_BASE + 7'd3, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h00, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hFF, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hA5, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h5A, 1, 0, 7'd0, 7'd0);
        // partial group only
        add_row(ROW_CFG,  16'd2,     KIND_START, 8'h00, 1, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 1, CHAR_BASE + 7'd2, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hFF, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h00, 0, 0, 7'd0, 7'd0);
        // restart in the middle of a transfer
        add_row(ROW_CFG,  16'd5,     KIND_START, 8'h00, 1, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 1, CHAR_BASE + 7'd5, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h01, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h02, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 1, CHAR_BASE + 7'd5, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h80, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h7F, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h01, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hFE, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h55, 0, 0, 7'd0, 7'd0);
        // largest length: full first line
        add_row(ROW_CFG,  16'hFFFF,  KIND_START, 8'h00, 1, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_START, 8'h00, 1, 1, CHAR_BASE + 7'd45, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h3C, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'hC3, 0, 0, 7'd0, 7'd0);
        add_row(ROW_ITEM, 16'd0,     KIND_DATA,  8'h0F, 0, 0, 7'd0, 7'd0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                wait_drained();
                write_total_len(dir_rows[i].len);
            end
            else begin
                send_item(dir_rows[i].kind, dir_rows[i].dbyte, dir_rows[i].typed,
                          dir_rows[i].n, dir_rows[i].ch0, dir_rows[i].ch1);
            end
        end

        rand_cnt = 0;
        tr = 0;
        // every idling phase gets at least one transfer
        while (rand_cnt < RAND_ITEMS || tr < NUM_PHASES) begin
            if (tr == 0) begin
                len = 16'd48;
            end
            else begin
                r = $urandom_range(99);
                if (r < 8)
                    len = 16'd0;
                else if (r < 25)
                    len = 16'($urandom_range(50, 43));
                else
                    len = 16'($urandom_range(12, 1));
            end
            if (tr == 0 || len != len_reg || $urandom_range(1) == 0) begin
                wait_drained();
                write_total_len(len);
            end
            set_phase(tr);
            send_item(KIND_START, 8'($urandom_range(255)), 0, 0, 7'd0, 7'd0);
            rand_cnt++;
            // broken transfer: cut short, the next start abandons it
            n_data = (tr != 0 && $urandom_range(99) < 15) ? $urandom_range(len) : len;
            for (int j = 0; j < n_data; j++) begin
                if (tr == 0 && j == n_data / 2) begin
                    push <= 1'b0;
                    while (exp_chars.size() != 0)
                        @(negedge clk);
                end
                send_item(KIND_DATA, 8'($urandom_range(255)), 0, 0, 7'd0, 7'd0);
                rand_cnt++;
            end
            if (n_data == len && $urandom_range(99) < 15) begin
                repeat ($urandom_range(3, 1))
                    send_item(KIND_DATA, 8'($urandom_range(255)), 0, 0, 7'd0, 7'd0);
            end
            tr++;
        end

        push <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0 && exp_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
src/uule_pkg.sv
src/uule_front.sv
src/uule_queue.sv
src/uule_back.sv
src/uuencode_line_encoder.sv
src/uule_checker.sv
test/tb_uuencode_line_encoder.sv
